@@ hdl/dts_pkg.sv @@
package dts_pkg;

    localparam int TIMER_SLOTS_DEF = 16;
    localparam int MAX_FIRES_DEF   = 8;

    localparam int ID_W = 32;
    localparam int DL_W = 40;
    localparam int IV_W = 24;

    localparam logic [1:0] REQ_SCHED  = 2'd0;
    localparam logic [1:0] REQ_CANCEL = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    localparam logic [1:0] KIND_SCHED  = 2'd0;
    localparam logic [1:0] KIND_CANCEL = 2'd1;
    localparam logic [1:0] KIND_FIRE   = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FREE,
        ST_SCAN,
        ST_ACT,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        OP_CANCEL,
        OP_FIRE,
        OP_MIN
    } t_op;

    typedef struct packed {
        logic [ID_W-1:0] ident;
        logic [DL_W-1:0] deadline;
        logic [IV_W-1:0] interval;
        logic            repeats;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic load;
        t_op  op;
    } t_pick_ctl;

    typedef struct packed {
        logic   hit;
        t_entry entry;
    } t_pick_res;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] timer_id;
        logic            found;
        logic            pending;
        logic [IV_W-1:0] next_wait;
        logic            last;
    } t_result;

endpackage

@@ hdl/dts_slot_mem.sv @@
module dts_slot_mem #(
    parameter int DEPTH = dts_pkg::TIMER_SLOTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  dts_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output dts_pkg::t_entry o_rdata
);

    dts_pkg::t_entry mem [DEPTH];
    dts_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/dts_pick.sv @@
module dts_pick #(
    parameter int IDX_W = $clog2(dts_pkg::TIMER_SLOTS_DEF)
) (
    input  logic                        i_clk,
    input  dts_pkg::t_pick_ctl          i_ctl,
    input  logic                        i_cand_valid,
    input  logic [IDX_W-1:0]            i_cand_idx,
    input  dts_pkg::t_entry             i_cand,
    input  logic [dts_pkg::DL_W-1:0]    i_clock,
    input  logic [dts_pkg::ID_W-1:0]    i_cancel_id,
    output dts_pkg::t_pick_res          o_best,
    output logic [IDX_W-1:0]            o_best_idx
);

    logic               r_hit;
    dts_pkg::t_entry    r_best;
    logic [IDX_W-1:0]   r_idx;
    logic               take;
    logic               dl_less;
    logic               dl_same;

    assign dl_less = i_cand.deadline < r_best.deadline;
    assign dl_same = i_cand.deadline == r_best.deadline;

    always_comb begin
        take = 1'b0;
        case (i_ctl.op)
            dts_pkg::OP_CANCEL: take = i_cand_valid && !r_hit && i_cand.ident == i_cancel_id;
            // earliest due deadline; on a tie the larger identifier, then the lower slot
            dts_pkg::OP_FIRE: take = i_cand_valid && i_cand.deadline <= i_clock &&
                                     (!r_hit || dl_less ||
                                      (dl_same && i_cand.ident > r_best.ident));
            dts_pkg::OP_MIN: take = i_cand_valid && (!r_hit || dl_less);
            default: take = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_hit <= 1'b0;
        end else if (i_ctl.load && take) begin
            r_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && take) begin
            r_best <= i_cand;
            r_idx  <= i_cand_idx;
        end
    end

    assign o_best.hit   = r_hit;
    assign o_best.entry = r_best;
    assign o_best_idx   = r_idx;

endmodule

@@ hdl/deadline_timer_scheduler.sv @@
// Table of TIMER_SLOTS millisecond timers kept in one slot memory with a registered
// read. Every request walks the table one slot per cycle through the single read
// port. A tick fires at most MAX_FIRES timers, its budget. Each fire is a full scan
// for the earliest due timer followed by a write back of the new deadline for a
// repeating timer or a release of the slot for a one-shot. A scan that finds nothing
// due, or the end of the budget, hands over to a closing scan that finds the soonest
// deadline. One request is worked at a time; a result waits in the output register
// while the next one is taken.
module deadline_timer_scheduler #(
    parameter int TIMER_SLOTS = dts_pkg::TIMER_SLOTS_DEF,
    parameter int MAX_FIRES   = dts_pkg::MAX_FIRES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [1:0]               i_req_type,
    input  logic [dts_pkg::IV_W-1:0] i_delay_ms,
    input  logic                     i_repeat_mode,
    input  logic [dts_pkg::ID_W-1:0] i_cancel_id,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [1:0]               o_result_kind,
    output logic [dts_pkg::ID_W-1:0] o_timer_id,
    output logic                     o_found,
    output logic                     o_pending,
    output logic [dts_pkg::IV_W-1:0] o_next_wait,
    output logic                     o_last
);

    localparam int IDX_W  = $clog2(TIMER_SLOTS);
    localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);
    localparam int FIRE_W = $clog2(MAX_FIRES + 1);
    localparam int DL_W   = dts_pkg::DL_W;
    localparam int ID_W   = dts_pkg::ID_W;
    localparam int IV_W   = dts_pkg::IV_W;

    dts_pkg::t_state    r_state, n_state;
    dts_pkg::t_op       r_op, n_op;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [FIRE_W-1:0]  r_fires, n_fires;
    logic [DL_W-1:0]    r_clock, n_clock;
    logic [ID_W-1:0]    r_next_id, n_next_id;
    logic [TIMER_SLOTS-1:0] r_valid, n_valid;
    logic [IV_W-1:0]    r_delay, n_delay;
    logic               r_rep, n_rep;
    logic [ID_W-1:0]    r_cid, n_cid;
    dts_pkg::t_result   r_res, n_res;
    dts_pkg::t_result   r_out;
    logic               r_out_vld;
    logic               r_rd_vld, n_rd_vld;
    logic [IDX_W-1:0]   r_rd_idx;

    logic               in_take;
    logic               out_free;
    logic               scan_end;
    logic [IDX_W-1:0]   cnt_idx;
    logic               sched_take;
    logic [IV_W-1:0]    delay_eff;
    logic [ID_W-1:0]    id_inc;
    logic [DL_W-1:0]    wait_diff;

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    dts_pkg::t_entry    mem_wdata;
    dts_pkg::t_entry    mem_rdata;

    dts_pkg::t_pick_ctl pick_ctl;
    dts_pkg::t_pick_res best;
    logic [IDX_W-1:0]   best_idx;

    assign o_ready    = (r_state == dts_pkg::ST_IDLE);
    assign in_take    = i_valid && o_ready;
    assign out_free   = !r_out_vld || i_ready;
    assign scan_end   = (r_cnt == CNT_W'(TIMER_SLOTS));
    assign cnt_idx    = r_cnt[IDX_W-1:0];
    assign sched_take = (r_state == dts_pkg::ST_FREE) && !scan_end && !r_valid[cnt_idx];
    assign delay_eff  = (r_delay == '0) ? IV_W'(1) : r_delay;
    assign id_inc     = r_next_id + ID_W'(1);
    assign wait_diff  = best.entry.deadline - r_clock;

    dts_slot_mem #(
        .DEPTH (TIMER_SLOTS),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (cnt_idx),
        .o_rdata (mem_rdata)
    );

    dts_pick #(
        .IDX_W (IDX_W)
    ) u_pick (
        .i_clk        (i_clk),
        .i_ctl        (pick_ctl),
        .i_cand_valid (r_valid[r_rd_idx]),
        .i_cand_idx   (r_rd_idx),
        .i_cand       (mem_rdata),
        .i_clock      (r_clock),
        .i_cancel_id  (r_cid),
        .o_best       (best),
        .o_best_idx   (best_idx)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dts_pkg::ST_IDLE: begin
                if (in_take) begin
                    unique case (i_req_type)
                        dts_pkg::REQ_SCHED:  n_state = dts_pkg::ST_FREE;
                        dts_pkg::REQ_CANCEL: n_state = dts_pkg::ST_SCAN;
                        dts_pkg::REQ_TICK:   n_state = dts_pkg::ST_SCAN;
                        default:             n_state = dts_pkg::ST_IDLE;
                    endcase
                end
            end
            dts_pkg::ST_FREE: begin
                if (sched_take || scan_end) begin
                    n_state = dts_pkg::ST_EMIT;
                end
            end
            dts_pkg::ST_SCAN: begin
                if (scan_end) begin
                    n_state = dts_pkg::ST_ACT;
                end
            end
            dts_pkg::ST_ACT: begin
                if (r_op == dts_pkg::OP_FIRE && !best.hit) begin
                    n_state = dts_pkg::ST_SCAN;
                end else begin
                    n_state = dts_pkg::ST_EMIT;
                end
            end
            dts_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = (r_op == dts_pkg::OP_FIRE) ? dts_pkg::ST_SCAN : dts_pkg::ST_IDLE;
                end
            end
            default: n_state = dts_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_op      = r_op;
        n_cnt     = r_cnt;
        n_fires   = r_fires;
        n_clock   = r_clock;
        n_next_id = r_next_id;
        n_valid   = r_valid;
        n_delay   = r_delay;
        n_rep     = r_rep;
        n_cid     = r_cid;
        n_res     = r_res;
        n_rd_vld  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = cnt_idx;
        mem_wdata = best.entry;
        pick_ctl.clear = 1'b0;
        pick_ctl.load  = r_rd_vld;
        pick_ctl.op    = r_op;

        unique case (r_state)
            dts_pkg::ST_IDLE: begin
                if (in_take) begin
                    n_delay = i_delay_ms;
                    n_rep   = i_repeat_mode;
                    n_cid   = i_cancel_id;
                    n_cnt   = '0;
                    unique case (i_req_type)
                        dts_pkg::REQ_CANCEL: begin
                            n_op = dts_pkg::OP_CANCEL;
                            pick_ctl.clear = 1'b1;
                        end
                        dts_pkg::REQ_TICK: begin
                            n_op    = dts_pkg::OP_FIRE;
                            n_clock = r_clock + DL_W'(1);
                            n_fires = '0;
                            pick_ctl.clear = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            dts_pkg::ST_FREE: begin
                n_res = '{kind: dts_pkg::KIND_SCHED, timer_id: '0, found: 1'b0,
                          pending: 1'b0, next_wait: '0, last: 1'b1};
                if (sched_take) begin
                    mem_we    = 1'b1;
                    mem_waddr = cnt_idx;
                    mem_wdata = '{ident: r_next_id,
                                  deadline: r_clock + DL_W'(delay_eff),
                                  interval: delay_eff, repeats: r_rep};
                    n_valid[cnt_idx] = 1'b1;
                    n_res.timer_id   = r_next_id;
                    // skip identifier zero on wrap
                    n_next_id = (id_inc == '0) ? ID_W'(1) : id_inc;
                end else if (!scan_end) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            dts_pkg::ST_SCAN: begin
                if (!scan_end) begin
                    n_rd_vld = 1'b1;
                    n_cnt    = r_cnt + CNT_W'(1);
                end
            end
            dts_pkg::ST_ACT: begin
                n_res = '{kind: dts_pkg::KIND_CANCEL, timer_id: '0, found: 1'b0,
                          pending: 1'b0, next_wait: '0, last: 1'b1};
                case (r_op)
                    dts_pkg::OP_CANCEL: begin
                        n_res.found = best.hit;
                        if (best.hit) begin
                            n_valid[best_idx] = 1'b0;
                        end
                    end
                    dts_pkg::OP_FIRE: begin
                        if (best.hit) begin
                            n_res.kind     = dts_pkg::KIND_FIRE;
                            n_res.timer_id = best.entry.ident;
                            n_res.last     = 1'b0;
                            n_fires        = r_fires + FIRE_W'(1);
                            if (best.entry.repeats) begin
                                mem_we             = 1'b1;
                                mem_waddr          = best_idx;
                                mem_wdata.deadline = r_clock + DL_W'(best.entry.interval);
                            end else begin
                                n_valid[best_idx] = 1'b0;
                            end
                        end else begin
                            n_op  = dts_pkg::OP_MIN;
                            n_cnt = '0;
                            pick_ctl.clear = 1'b1;
                        end
                    end
                    dts_pkg::OP_MIN: begin
                        n_res.kind    = dts_pkg::KIND_DONE;
                        n_res.pending = best.hit;
                        if (best.hit && best.entry.deadline > r_clock) begin
                            // saturate the wait at the field width
                            n_res.next_wait = (|wait_diff[DL_W-1:IV_W]) ? '1 :
                                              wait_diff[IV_W-1:0];
                        end
                    end
                    default: ;
                endcase
            end
            dts_pkg::ST_EMIT: begin
                if (out_free && r_op == dts_pkg::OP_FIRE) begin
                    n_cnt = '0;
                    pick_ctl.clear = 1'b1;
                    if (r_fires == FIRE_W'(MAX_FIRES)) begin
                        n_op = dts_pkg::OP_MIN;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= dts_pkg::ST_IDLE;
            r_op      <= dts_pkg::OP_CANCEL;
            r_cnt     <= '0;
            r_fires   <= '0;
            r_clock   <= '0;
            r_next_id <= ID_W'(1);
            r_valid   <= '0;
            r_out_vld <= 1'b0;
            r_rd_vld  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_op      <= n_op;
            r_cnt     <= n_cnt;
            r_fires   <= n_fires;
            r_clock   <= n_clock;
            r_next_id <= n_next_id;
            r_valid   <= n_valid;
            r_rd_vld  <= n_rd_vld;
            if (r_state == dts_pkg::ST_EMIT && out_free) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_delay  <= n_delay;
        r_rep    <= n_rep;
        r_cid    <= n_cid;
        r_res    <= n_res;
        r_rd_idx <= cnt_idx;
        if (r_state == dts_pkg::ST_EMIT && out_free) begin
            r_out <= r_res;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_result_kind = r_out.kind;
    assign o_timer_id    = r_out.timer_id;
    assign o_found       = r_out.found;
    assign o_pending     = r_out.pending;
    assign o_next_wait   = r_out.next_wait;
    assign o_last        = r_out.last;

    a_fire_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fires <= FIRE_W'(MAX_FIRES))
        else $error("fire count exceeds budget");

    a_open_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_result_kind == dts_pkg::KIND_FIRE))
        else $error("non-final result is not a fired timer");

    a_sched_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sched_take |=> ($countones(r_valid) == $past($countones(r_valid)) + 1))
        else $error("schedule did not occupy exactly one free slot");

endmodule
